// ===== rtl/qrs_pkg.sv =====
`default_nettype none

package qrs_pkg;

   localparam int TIME_BITS      = 48;
   localparam int COUNT_BITS     = 32;
   localparam int POS_BITS       = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      DIR_CW     = 2'd0,
      DIR_CCW    = 2'd1,
      DIR_GLITCH = 2'd2,
      DIR_STILL  = 2'd3
   } dir_type;

   typedef struct packed {
      logic                 seed;
      dir_type              dir;
      logic [TIME_BITS-1:0] stamp;
   } step_type;

   typedef struct packed {
      logic     valid;
      step_type step;
   } push_type;

   typedef struct packed {
      logic     valid;
      step_type step;
   } head_type;

   function automatic dir_type step_class(input logic old_a, input logic old_b,
                                          input logic new_a, input logic new_b);
      dir_type d;
      unique case ({new_b, new_a, old_b, old_a})
         4'b0000, 4'b0101, 4'b1010, 4'b1111: d = DIR_STILL;
         4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_CW;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_CCW;
         default:                            d = DIR_GLITCH;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/qrs_front.sv =====
`default_nettype none

module qrs_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_level_a,
   input  wire logic                         req_level_b,
   input  wire logic [qrs_pkg::TIME_BITS-1:0] req_sample_time,
   input  wire logic                         queue_full,
   output qrs_pkg::push_type                 push
);

   logic             primed_ff, primed_in;
   logic             last_a_ff, last_a_in;
   logic             last_b_ff, last_b_in;
   logic             accept;
   qrs_pkg::dir_type cls;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign cls       = qrs_pkg::step_class(last_a_ff, last_b_ff, req_level_a, req_level_b);

   always_comb begin
      primed_in  = primed_ff;
      last_a_in  = last_a_ff;
      last_b_in  = last_b_ff;
      push.valid = 1'b0;
      push.step.seed  = !primed_ff;
      push.step.dir   = cls;
      push.step.stamp = req_sample_time;
      if (accept) begin
         primed_in  = 1'b1;
         last_a_in  = req_level_a;
         last_b_in  = req_level_b;
         push.valid = !primed_ff || (cls != qrs_pkg::DIR_STILL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         last_a_ff <= 1'b0;
         last_b_ff <= 1'b0;
      end else begin
         primed_ff <= primed_in;
         last_a_ff <= last_a_in;
         last_b_ff <= last_b_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/qrs_queue.sv =====
`default_nettype none

module qrs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qrs_pkg::push_type push,
   output logic                   full,
   output qrs_pkg::head_type      head,
   input  wire logic              pop
);

   qrs_pkg::step_type                   entry_ff [qrs_pkg::QUEUE_DEPTH];
   logic [qrs_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [qrs_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [qrs_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full       = (count_ff == qrs_pkg::QUEUE_CNT_BITS'(qrs_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.step  = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.step;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/qrs_back.sv =====
`default_nettype none

module qrs_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire qrs_pkg::head_type                    head,
   output logic                                      pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_run_direction,
   output logic signed [qrs_pkg::POS_BITS-1:0]       rsp_position,
   output logic [qrs_pkg::COUNT_BITS-1:0]            rsp_step_count,
   output logic [qrs_pkg::COUNT_BITS-1:0]            rsp_glitch_count,
   output logic [qrs_pkg::TIME_BITS-1:0]             rsp_run_start,
   output logic [qrs_pkg::TIME_BITS-1:0]             rsp_run_end
);

   qrs_pkg::dir_type                  prev_dir_ff, prev_dir_in;
   logic [qrs_pkg::POS_BITS-1:0]      pos_ff, pos_in;
   logic [qrs_pkg::COUNT_BITS-1:0]    steps_ff, steps_in;
   logic [qrs_pkg::COUNT_BITS-1:0]    glitches_ff, glitches_in;
   logic [qrs_pkg::TIME_BITS-1:0]     start_ff, start_in;
   logic [qrs_pkg::TIME_BITS-1:0]     end_ff, end_in;
   logic [qrs_pkg::TIME_BITS-1:0]     cur_ff, cur_in;

   logic                              out_valid_ff, out_valid_in;
   logic [1:0]                        out_dir_ff, out_dir_in;
   logic [qrs_pkg::POS_BITS-1:0]      out_pos_ff, out_pos_in;
   logic [qrs_pkg::COUNT_BITS-1:0]    out_steps_ff, out_steps_in;
   logic [qrs_pkg::COUNT_BITS-1:0]    out_glitches_ff, out_glitches_in;
   logic [qrs_pkg::TIME_BITS-1:0]     out_start_ff, out_start_in;
   logic [qrs_pkg::TIME_BITS-1:0]     out_end_ff, out_end_in;

   logic                              is_step;
   logic                              is_glitch;
   logic                              change;
   logic                              emit;
   logic                              out_free;
   logic [qrs_pkg::POS_BITS-1:0]      pos_step;
   logic [qrs_pkg::COUNT_BITS-1:0]    steps_step;
   logic [qrs_pkg::COUNT_BITS-1:0]    glitches_step;
   logic [qrs_pkg::TIME_BITS-1:0]     end_step;
   logic [qrs_pkg::TIME_BITS-1:0]     cur_step;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign is_step   = (head.step.dir == qrs_pkg::DIR_CW) || (head.step.dir == qrs_pkg::DIR_CCW);
   assign is_glitch = (head.step.dir == qrs_pkg::DIR_GLITCH);

   always_comb begin
      pos_step      = pos_ff;
      steps_step    = steps_ff;
      glitches_step = glitches_ff;
      end_step      = end_ff;
      cur_step      = cur_ff;
      if (is_glitch && (glitches_ff != '1)) begin
         glitches_step = glitches_ff + 1'b1;
      end
      if (is_step) begin
         if (steps_ff != '1) begin
            steps_step = steps_ff + 1'b1;
         end
         if (head.step.dir == qrs_pkg::DIR_CW) begin
            pos_step = pos_ff - 1'b1;
         end else begin
            pos_step = pos_ff + 1'b1;
         end
         end_step = cur_ff;
         cur_step = head.step.stamp;
      end
   end

   assign change = !head.step.seed && (head.step.dir != prev_dir_ff);
   assign emit   = head.valid && change &&
                   ((glitches_step != '0) || (prev_dir_ff != qrs_pkg::DIR_GLITCH));
   assign pop    = head.valid && (!emit || out_free);

   always_comb begin
      prev_dir_in = prev_dir_ff;
      pos_in      = pos_ff;
      steps_in    = steps_ff;
      glitches_in = glitches_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      cur_in      = cur_ff;
      if (pop) begin
         if (head.step.seed) begin
            start_in = head.step.stamp;
            end_in   = head.step.stamp;
            cur_in   = head.step.stamp;
         end else begin
            pos_in      = pos_step;
            steps_in    = steps_step;
            glitches_in = glitches_step;
            end_in      = end_step;
            cur_in      = cur_step;
            if (change) begin
               start_in    = cur_step;
               prev_dir_in = head.step.dir;
               steps_in    = '0;
               glitches_in = '0;
            end
         end
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_dir_in      = out_dir_ff;
      out_pos_in      = out_pos_ff;
      out_steps_in    = out_steps_ff;
      out_glitches_in = out_glitches_ff;
      out_start_in    = out_start_ff;
      out_end_in      = out_end_ff;
      if (pop && emit) begin
         out_valid_in    = 1'b1;
         out_dir_in      = prev_dir_ff;
         out_pos_in      = pos_step;
         out_steps_in    = steps_step;
         out_glitches_in = glitches_step;
         out_start_in    = start_ff;
         out_end_in      = end_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_dir_ff  <= qrs_pkg::DIR_GLITCH;
         pos_ff       <= '0;
         steps_ff     <= '0;
         glitches_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prev_dir_ff  <= prev_dir_in;
         pos_ff       <= pos_in;
         steps_ff     <= steps_in;
         glitches_ff  <= glitches_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff        <= start_in;
      end_ff          <= end_in;
      cur_ff          <= cur_in;
      out_dir_ff      <= out_dir_in;
      out_pos_ff      <= out_pos_in;
      out_steps_ff    <= out_steps_in;
      out_glitches_ff <= out_glitches_in;
      out_start_ff    <= out_start_in;
      out_end_ff      <= out_end_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_run_direction = out_dir_ff;
   assign rsp_position      = $signed(out_pos_ff);
   assign rsp_step_count    = out_steps_ff;
   assign rsp_glitch_count  = out_glitches_ff;
   assign rsp_run_start     = out_start_ff;
   assign rsp_run_end       = out_end_ff;

endmodule

`default_nettype wire

// ===== rtl/quadrature_run_segmenter_top.sv =====
// Quadrature run segmenter: an x4 decoder for encoder channels A and B that
// reports the motion as runs of one class (clockwise, counter-clockwise, glitch).
// The request channel takes one sample per transaction: both levels and the
// sample time. The first sample after reset only seeds the levels and times.
// Standstill samples and samples that stay within the current run give no
// response; a sample that changes the class gives one run record on the
// response channel, except when the ending run is a glitch run with no counted glitch.
// The front end classifies each sample against the previous levels in the
// cycle it is accepted; the seed and every non-standstill sample go into a
// four-entry queue. The back end updates position, counts and time marks for
// one queued step per cycle and loads a record into the response register.
// With an empty queue, a run's last step passes the queue entry, then the
// response register. Throughput is one sample per cycle unless stalled.
// When the receiver stalls, the response register holds its record, the back
// end stops only on a step that would emit, and the queue holds that step and
// up to three more before req_ready drops. Synchronous reset clears the levels,
// position, counts and all valid state; no response is pending after reset.
`default_nettype none

module quadrature_run_segmenter_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_level_a,
   input  wire logic                              req_level_b,
   input  wire logic [qrs_pkg::TIME_BITS-1:0]     req_sample_time,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_run_direction,
   output logic signed [qrs_pkg::POS_BITS-1:0]    rsp_position,
   output logic [qrs_pkg::COUNT_BITS-1:0]         rsp_step_count,
   output logic [qrs_pkg::COUNT_BITS-1:0]         rsp_glitch_count,
   output logic [qrs_pkg::TIME_BITS-1:0]          rsp_run_start,
   output logic [qrs_pkg::TIME_BITS-1:0]          rsp_run_end
);

   qrs_pkg::push_type push;
   qrs_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   qrs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_level_a     (req_level_a),
      .req_level_b     (req_level_b),
      .req_sample_time (req_sample_time),
      .queue_full      (queue_full),
      .push            (push)
   );

   qrs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   qrs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_run_direction (rsp_run_direction),
      .rsp_position      (rsp_position),
      .rsp_step_count    (rsp_step_count),
      .rsp_glitch_count  (rsp_glitch_count),
      .rsp_run_start     (rsp_run_start),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

`default_nettype wire

// ===== rtl/qrs_checker.sv =====
`default_nettype none

module qrs_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [1:0]                        rsp_run_direction,
   input  wire logic [qrs_pkg::COUNT_BITS-1:0]    rsp_step_count,
   input  wire logic [qrs_pkg::COUNT_BITS-1:0]    rsp_glitch_count
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_direction) &&
                                  $stable(rsp_step_count) && $stable(rsp_glitch_count))
      else $error("stalled response transaction changed");

   a_direction_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_direction == qrs_pkg::DIR_CW) ||
                    (rsp_run_direction == qrs_pkg::DIR_CCW) ||
                    (rsp_run_direction == qrs_pkg::DIR_GLITCH))
      else $error("record carries the standstill class");

   a_run_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_count != '0) || (rsp_glitch_count != '0))
      else $error("run reported without any counted transition");

   a_glitch_run_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_run_direction == qrs_pkg::DIR_GLITCH) |-> rsp_glitch_count != '0)
      else $error("empty glitch run reported");

endmodule

bind quadrature_run_segmenter_top qrs_checker u_qrs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_run_direction (rsp_run_direction),
   .rsp_step_count    (rsp_step_count),
   .rsp_glitch_count  (rsp_glitch_count)
);

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_ITEMS   = 138;

   localparam logic [1:0] QUARTER_NONE = 2'd0;
   localparam logic [1:0] QUARTER_FWD  = 2'd1;
   localparam logic [1:0] QUARTER_HALF = 2'd2;
   localparam logic [1:0] QUARTER_BACK = 2'd3;

   localparam logic [qrs_pkg::TIME_BITS-1:0] TIME_MAX = '1;

   typedef struct packed {
      qrs_pkg::dir_type                     dir;
      logic signed [qrs_pkg::POS_BITS-1:0]  position;
      logic [qrs_pkg::COUNT_BITS-1:0]       steps;
      logic [qrs_pkg::COUNT_BITS-1:0]       glitches;
      logic [qrs_pkg::TIME_BITS-1:0]        first_time;
      logic [qrs_pkg::TIME_BITS-1:0]        last_time;
   } run_rec_type;

   typedef struct {
      logic                          a;
      logic                          b;
      logic [qrs_pkg::TIME_BITS-1:0] t;
      bit                            typed;
      run_rec_type                   rec;
   } stim_row_type;

   localparam run_rec_type NO_REC = '0;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_level_a;
   logic                                 req_level_b;
   logic [qrs_pkg::TIME_BITS-1:0]        req_sample_time;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [1:0]                           rsp_run_direction;
   logic signed [qrs_pkg::POS_BITS-1:0]  rsp_position;
   logic [qrs_pkg::COUNT_BITS-1:0]       rsp_step_count;
   logic [qrs_pkg::COUNT_BITS-1:0]       rsp_glitch_count;
   logic [qrs_pkg::TIME_BITS-1:0]        rsp_run_start;
   logic [qrs_pkg::TIME_BITS-1:0]        rsp_run_end;

   quadrature_run_segmenter_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_level_a       (req_level_a),
      .req_level_b       (req_level_b),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_run_direction (rsp_run_direction),
      .rsp_position      (rsp_position),
      .rsp_step_count    (rsp_step_count),
      .rsp_glitch_count  (rsp_glitch_count),
      .rsp_run_start     (rsp_run_start),
      .rsp_run_end       (rsp_run_end)
   );

   run_rec_type run_records_due[$];
   stim_row_type directed[$];
   int errors;
   int cycle_count;
   int send_idle_pct;
   int stall_pct;
   bit hold_rsp;

   bit                                  primed;
   logic                                lvl_a;
   logic                                lvl_b;
   qrs_pkg::dir_type                    run_dir;
   logic signed [qrs_pkg::POS_BITS-1:0] pos_now;
   logic [qrs_pkg::COUNT_BITS-1:0]      steps_now;
   logic [qrs_pkg::COUNT_BITS-1:0]      glitches_now;
   logic [qrs_pkg::TIME_BITS-1:0]       mark_start;
   logic [qrs_pkg::TIME_BITS-1:0]       mark_end;
   logic [qrs_pkg::TIME_BITS-1:0]       step_time;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** quadrature_run_segmenter_top: FAILED **");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      run_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (run_records_due.size() == 0) begin
            $error("run record with no expectation waiting");
            errors++;
         end else begin
            want = run_records_due.pop_front();
            check_field("run_direction", 64'(want.dir), 64'(rsp_run_direction));
            check_field("position", 64'(unsigned'(want.position)),
                        64'(unsigned'(rsp_position)));
            check_field("step_count", 64'(want.steps), 64'(rsp_step_count));
            check_field("glitch_count", 64'(want.glitches), 64'(rsp_glitch_count));
            check_field("run_start", 64'(want.first_time), 64'(rsp_run_start));
            check_field("run_end", 64'(want.last_time), 64'(rsp_run_end));
         end
      end
   end

   task automatic send_sample(input logic a, input logic b,
                              input logic [qrs_pkg::TIME_BITS-1:0] t,
                              input bit typed, input run_rec_type typed_rec);
      logic [1:0] g_old;
      logic [1:0] g_new;
      logic [1:0] delta;
      qrs_pkg::dir_type cls;
      run_rec_type rec;
      bit emit;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_level_a     <= a;
      req_level_b     <= b;
      req_sample_time <= t;
      do @(posedge clock); while (!req_ready);

      emit = 1'b0;
      rec  = NO_REC;
      if (!primed) begin
         primed     = 1'b1;
         lvl_a      = a;
         lvl_b      = b;
         mark_start = t;
         mark_end   = t;
         step_time  = t;
      end else begin
         g_old = {lvl_a, lvl_a ^ lvl_b};
         g_new = {a, a ^ b};
         delta = g_new - g_old;
         lvl_a = a;
         lvl_b = b;
         if (delta != QUARTER_NONE) begin
            case (delta)
               QUARTER_FWD:  cls = qrs_pkg::DIR_CW;
               QUARTER_BACK: cls = qrs_pkg::DIR_CCW;
               default:      cls = qrs_pkg::DIR_GLITCH;
            endcase
            if (cls == qrs_pkg::DIR_GLITCH) begin
               if (glitches_now != '1) glitches_now++;
            end else begin
               if (steps_now != '1) steps_now++;
               pos_now   = (cls == qrs_pkg::DIR_CW) ? pos_now - 1 : pos_now + 1;
               mark_end  = step_time;
               step_time = t;
            end
            if (cls != run_dir) begin
               if (glitches_now != 0 || run_dir != qrs_pkg::DIR_GLITCH) begin
                  emit = 1'b1;
                  rec  = '{run_dir, pos_now, steps_now, glitches_now, mark_start, mark_end};
               end
               mark_start   = step_time;
               run_dir      = cls;
               steps_now    = '0;
               glitches_now = '0;
            end
         end
      end
      if (emit) run_records_due.push_back(typed ? typed_rec : rec);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (run_records_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic                          cur_a;
      logic                          cur_b;
      logic [qrs_pkg::TIME_BITS-1:0] cur_t;
      logic [1:0]                    g;
      logic [1:0]                    delta;
      logic [63:0]                   wide;
      bit                            tend_back;
      int                            r;

      errors          = 0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_rsp        = 1'b0;
      req_valid       = 1'b0;
      req_level_a     = 1'b0;
      req_level_b     = 1'b0;
      req_sample_time = '0;
      reset           = 1'b1;

      primed       = 1'b0;
      lvl_a        = 1'b0;
      lvl_b        = 1'b0;
      run_dir      = qrs_pkg::DIR_GLITCH;
      pos_now      = '0;
      steps_now    = '0;
      glitches_now = '0;
      mark_start   = '0;
      mark_end     = '0;
      step_time    = '0;

      directed.push_back('{1'b0, 1'b0, 48'd0, 1'b0, NO_REC});
      directed.push_back('{1'b1, 1'b0, 48'd5, 1'b0, NO_REC});
      directed.push_back('{1'b1, 1'b1, 48'd6, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b0, 48'd7, 1'b1,
                           '{qrs_pkg::DIR_CCW, 32'sd2, 32'd1, 32'd1, 48'd5, 48'd5}});
      directed.push_back('{1'b0, 1'b0, 48'd8, 1'b0, NO_REC});
      directed.push_back('{1'b1, 1'b1, 48'd9, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b1, 48'd10, 1'b1,
                           '{qrs_pkg::DIR_GLITCH, 32'sd3, 32'd1, 32'd1, 48'd6, 48'd6}});
      directed.push_back('{1'b1, 1'b1, TIME_MAX, 1'b1,
                           '{qrs_pkg::DIR_CCW, 32'sd2, 32'd1, 32'd0, 48'd10, 48'd10}});
      directed.push_back('{1'b1, 1'b0, TIME_MAX, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b0, 48'd0, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b1, 48'd1, 1'b0, NO_REC});
      directed.push_back('{1'b1, 1'b1, 48'd2, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b0, 48'd3, 1'b1,
                           '{qrs_pkg::DIR_CW, -32'sd2, 32'd4, 32'd1, TIME_MAX, 48'd1}});
      directed.push_back('{1'b1, 1'b1, 48'd4, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b0, 48'd5, 1'b0, NO_REC});
      directed.push_back('{1'b1, 1'b0, 48'd6, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b0, 48'hAAAA_AAAA_AAAA, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b1, 48'h5555_5555_5555, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b1, 48'h5555_5555_5556, 1'b0, NO_REC});
      directed.push_back('{1'b0, 1'b0, 48'h5555_5555_5557, 1'b0, NO_REC});
      directed.push_back('{1'b1, 1'b1, 48'h5555_5555_5558, 1'b0, NO_REC});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_sample(directed[i].a, directed[i].b, directed[i].t,
                     directed[i].typed, directed[i].rec);
      cur_a     = directed[directed.size() - 1].a;
      cur_b     = directed[directed.size() - 1].b;
      cur_t     = directed[directed.size() - 1].t;
      tend_back = 1'b0;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  hold_rsp = 1'b1; end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(9) == 0) tend_back = ~tend_back;
            r = $urandom_range(99);
            if (r < 7)       delta = QUARTER_HALF;
            else if (r < 16) delta = QUARTER_NONE;
            else             delta = tend_back ? QUARTER_BACK : QUARTER_FWD;
            g     = {cur_a, cur_a ^ cur_b} + delta;
            cur_a = g[1];
            cur_b = g[1] ^ g[0];
            if ($urandom_range(19) == 0) begin
               wide  = {$urandom(), $urandom()};
               cur_t = wide[qrs_pkg::TIME_BITS-1:0];
            end else begin
               cur_t = cur_t + $urandom_range(1, 16);
            end
            send_sample(cur_a, cur_b, cur_t, 1'b0, NO_REC);
         end
         drain();
      end

      if (run_records_due.size() != 0) begin
         $error("%0d run records never arrived", run_records_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** quadrature_run_segmenter_top: PASSED **");
      end else begin
         $display("** quadrature_run_segmenter_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
